[rtl/core/max_falling_path_sum_macros.svh]
`ifndef MAX_FALLING_PATH_SUM_MACROS_SVH
`define MAX_FALLING_PATH_SUM_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define MFPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mfps assertion failed");

// next-cycle implication, checked on aclk outside reset
`define MFPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mfps assertion failed");

`endif

[rtl/core/mfps_pkg.sv]
`timescale 1ns / 1ps

package mfps_pkg;

    // path sums and matrix elements
    typedef logic signed [31:0] sum_t;
    typedef logic signed [15:0] cell_t;
    typedef logic [8:0]         width_cfg_t;

    localparam sum_t SUM_MIN = 32'sh8000_0000;
    localparam sum_t SUM_MAX = 32'sh7fff_ffff;

    // configuration register map
    localparam width_cfg_t ROW_WIDTH_RESET = 9'd256;
    localparam logic       REG_ROW_WIDTH   = 1'b0;

endpackage

[rtl/core/mfps_row_store.sv]
`timescale 1ns / 1ps

module mfps_row_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  mfps_pkg::sum_t  wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr_a,
    input  logic [AW-1:0]   rd_addr_b,
    output mfps_pkg::sum_t  rd_data_a,
    output mfps_pkg::sum_t  rd_data_b
);

    mfps_pkg::sum_t mem [0:DEPTH-1];
    mfps_pkg::sum_t rd_a_reg;
    mfps_pkg::sum_t rd_b_reg;

    // one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports, old data on a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[rtl/core/max_falling_path_sum.sv]
// result: the matrix_end element passes the compute stage into the result register, which drives m_tdata
// throughput: one element per cycle, set by the single add/compare stage and the
//   two-read-port row store; stalls only while a result waits on m_tready
// reset: aresetn synchronous active low; clears the handshake, column and row state
//   and sets row_width to 256; the row store itself is not cleared
`timescale 1ns / 1ps

module max_falling_path_sum #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // element input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cell_value
    input  logic        s_tlast,   // matrix_end
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] best_path_sum
    output logic [0:0]  m_tuser,   // [0] saturated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WW = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9;

    // configuration register
    mfps_pkg::width_cfg_t row_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= mfps_pkg::ROW_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mfps_pkg::REG_ROW_WIDTH) begin
            row_width_reg <= pwdata[8:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mfps_pkg::REG_ROW_WIDTH) ? {23'd0, row_width_reg} : 32'd0;

    // effective row width, clamped to 1..MAX_COLUMNS
    logic [WW-1:0] cfg_ext;
    logic [WW-1:0] w_eff;

    assign cfg_ext = WW'(row_width_reg);
    assign w_eff   = (cfg_ext == '0) ? WW'(1) :
                     (cfg_ext > WW'(MAX_COLUMNS)) ? WW'(MAX_COLUMNS) : cfg_ext;

    // front end: column position of the next element
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          first_reg;
    logic          first_next;
    logic [WW-1:0] col_inc;
    logic          has_right;
    logic [CW-1:0] rd_addr_b;
    logic          s_accept;

    assign col_inc   = WW'(col_reg) + WW'(1);
    assign has_right = col_inc < w_eff;
    assign rd_addr_b = (col_inc < WW'(MAX_COLUMNS)) ? CW'(col_inc) : '0;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        col_next   = col_reg;
        first_next = first_reg;
        if (s_accept) begin
            if (s_tlast) begin
                col_next   = '0;
                first_next = 1'b1;
            end else if (!has_right) begin
                col_next   = '0;
                first_next = 1'b0;
            end else begin
                col_next   = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

    // compute stage registers
    logic                  s1_valid_reg;
    mfps_pkg::cell_t       s1_value_reg;
    logic                  s1_last_reg;
    logic [CW-1:0]         s1_col_reg;
    logic                  s1_first_reg;
    logic                  s1_right_ok_reg;
    logic                  s1_row_done_reg;
    logic                  fwd_up_reg;
    logic                  fwd_right_reg;
    mfps_pkg::sum_t        fwd_val_reg;
    logic                  s1_fire;
    logic                  out_free;
    mfps_pkg::sum_t        s_val;

    assign out_free = !m_tvalid || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // payload and forwarding from the element leaving the stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_value_reg    <= s_tdata;
            s1_last_reg     <= s_tlast;
            s1_col_reg      <= col_reg;
            s1_first_reg    <= first_reg;
            s1_right_ok_reg <= has_right;
            s1_row_done_reg <= !has_right;
            fwd_up_reg      <= s1_valid_reg && (s1_col_reg == col_reg);
            fwd_right_reg   <= s1_valid_reg && has_right && (s1_col_reg == rd_addr_b);
            fwd_val_reg     <= s_val;
        end
    end

    // row store
    mfps_pkg::sum_t rd_up;
    mfps_pkg::sum_t rd_right;

    mfps_row_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (CW)
    ) u_row_store (
        .aclk      (aclk),
        .wr_en     (s1_fire),
        .wr_addr   (s1_col_reg),
        .wr_data   (s_val),
        .rd_en     (s_accept),
        .rd_addr_a (col_reg),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_up),
        .rd_data_b (rd_right)
    );

    // running row state
    mfps_pkg::sum_t left_reg;
    mfps_pkg::sum_t row_best_reg;
    logic           ovf_reg;

    // best of the three neighbors, add and saturate
    mfps_pkg::sum_t    up_val;
    mfps_pkg::sum_t    right_val;
    mfps_pkg::sum_t    best_a;
    mfps_pkg::sum_t    best;
    logic signed [32:0] sum_wide;
    logic              sat;
    mfps_pkg::sum_t    rb_val;
    logic              ovf_val;

    always_comb begin
        up_val    = fwd_up_reg ? fwd_val_reg : rd_up;
        right_val = fwd_right_reg ? fwd_val_reg : rd_right;
        best_a    = ((s1_col_reg != '0) && (left_reg > up_val)) ? left_reg : up_val;
        best      = (s1_right_ok_reg && (right_val > best_a)) ? right_val : best_a;
        if (s1_first_reg) begin
            sum_wide = 33'(s1_value_reg);
        end else begin
            sum_wide = 33'(best) + 33'(s1_value_reg);
        end
        sat = sum_wide[32] != sum_wide[31];
        if (!sat) begin
            s_val = sum_wide[31:0];
        end else if (sum_wide[32]) begin
            s_val = mfps_pkg::SUM_MIN;
        end else begin
            s_val = mfps_pkg::SUM_MAX;
        end
        rb_val  = (s_val > row_best_reg) ? s_val : row_best_reg;
        ovf_val = ovf_reg || sat;
    end

    // row and matrix bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            row_best_reg <= mfps_pkg::SUM_MIN;
            ovf_reg      <= 1'b0;
        end else if (s1_fire) begin
            if (s1_last_reg || s1_row_done_reg) begin
                left_reg     <= '0;
                row_best_reg <= mfps_pkg::SUM_MIN;
            end else begin
                left_reg     <= up_val;
                row_best_reg <= rb_val;
            end
            ovf_reg <= s1_last_reg ? 1'b0 : ovf_val;
        end
    end

    // result register
    logic           m_valid_reg;
    mfps_pkg::sum_t m_data_reg;
    logic           m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            m_data_reg <= rb_val;
            m_sat_reg  <= ovf_val;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

    // checks
`include "max_falling_path_sum_macros.svh"

    `MFPS_ASSERT_NEXT(a_result_only_on_end, out_free && !(s1_fire && s1_last_reg), !m_valid_reg)
    `MFPS_ASSERT_NOW(a_stage_row_flags, s1_valid_reg, s1_right_ok_reg != s1_row_done_reg)
    `MFPS_ASSERT_NEXT(a_end_restarts, s_accept && s_tlast, col_reg == '0 && first_reg)

endmodule
